[sv/ssop_pkg.sv]
package ssop_pkg;

  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegColXUpper = 3'd0;
  localparam logic [CfgIdxW-1:0] RegColXLower = 3'd1;
  localparam logic [CfgIdxW-1:0] RegColYUpper = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColYLower = 3'd3;
  localparam logic [CfgIdxW-1:0] RegColWUpper = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColWLower = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCursorX   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCursorY   = 3'd7;

  // One accepted object as it sits in the queue between front and back.
  typedef struct packed {
    logic [15:0]        object_id;
    logic               layer_first;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [30:0]        scale_x;
  } obj_t;

  typedef enum logic [3:0] {
    StIdle,
    StMul,
    StSum,
    StScreenNum,
    StDivStart,
    StDivRun,
    StDivDone,
    StDist,
    StDistAdd,
    StDecide,
    StOut
  } back_state_e;

endpackage

[sv/screen_space_object_pick_core.sv]
// Channel  | Handshake                   | Payload
// object   | obj_valid_i / obj_ready_o   | object_id_i layer_first_i world_*_i scale_x_i
// result   | res_valid_o / res_ready_i   | picked_id_o selected_o screen_*_o degenerate_o
// config   | cfg_we_i                    | cfg_idx_i cfg_data_i
//
// A front queue of two words takes objects while the back end works on one.
// The back end takes one object at a time: it forms eighteen products, each
// in a multiply state and a sum state, then runs a 64-bit serial divider up
// to eight times. Results are held until taken; reset clears the layer
// state, the queue and the configuration registers.
module screen_space_object_pick_core #(
  parameter int unsigned ScreenWidth  = 1600,
  parameter int unsigned ScreenHeight = 900,
  parameter int unsigned FracBits     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssop_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssop_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           obj_valid_i,
  output logic                           obj_ready_o,
  input  logic [15:0]                    object_id_i,
  input  logic                           layer_first_i,
  input  logic signed [31:0]             world_x_i,
  input  logic signed [31:0]             world_y_i,
  input  logic signed [31:0]             world_z_i,
  input  logic [30:0]                    scale_x_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [15:0]                    picked_id_o,
  output logic                           selected_o,
  output logic signed [31:0]             screen_x_o,
  output logic signed [31:0]             screen_y_o,
  output logic                           degenerate_o
);
  import ssop_pkg::*;

  logic [5:0][63:0] cols_q;
  logic [10:0] cursor_x_q;
  logic [9:0]  cursor_y_q;

  // Configuration registers; the cursor registers keep only their low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= '0;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCursorX: cursor_x_q <= cfg_data_i[10:0];
        RegCursorY: cursor_y_q <= cfg_data_i[9:0];
        RegColXUpper, RegColXLower, RegColYUpper,
        RegColYLower, RegColWUpper, RegColWLower:
          cols_q[cfg_idx_i] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  obj_t in_obj, q_obj;
  logic q_valid, q_ready;

  assign in_obj = '{object_id: object_id_i, layer_first: layer_first_i,
                    world_x: world_x_i, world_y: world_y_i, world_z: world_z_i,
                    scale_x: scale_x_i};

  ssop_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (obj_valid_i),
    .in_ready_o (obj_ready_o),
    .in_obj_i   (in_obj),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_obj_o  (q_obj)
  );

  ssop_back #(
    .ScreenWidth (ScreenWidth),
    .ScreenHeight(ScreenHeight),
    .FracBits    (FracBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .obj_valid_i (q_valid),
    .obj_ready_o (q_ready),
    .obj_i       (q_obj),
    .cols_i      (cols_q),
    .cursor_x_i  (cursor_x_q),
    .cursor_y_i  (cursor_y_q),
    .out_valid_o (res_valid_o),
    .out_ready_i (res_ready_i),
    .picked_id_o (picked_id_o),
    .selected_o  (selected_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .degenerate_o(degenerate_o)
  );

endmodule

[sv/ssop_queue.sv]
module ssop_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssop_pkg::obj_t in_obj_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssop_pkg::obj_t out_obj_o
);
  import ssop_pkg::*;

  // Two-entry queue.
  obj_t        mem_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_obj_o   = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_obj_i;
    end
  end

endmodule

[sv/ssop_div.sv]
module ssop_div #(
  parameter int unsigned Width = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  output logic             busy_o,
  output logic [Width-1:0] quo_o,
  output logic [Width-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  // Restoring divider, one quotient bit a cycle.
  logic [Width-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width:0]   trial;

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[Width-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(Width);
    end else if (busy_o) begin
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

[sv/ssop_back.sv]
module ssop_back #(
  parameter int unsigned ScreenWidth  = 1600,
  parameter int unsigned ScreenHeight = 900,
  parameter int unsigned FracBits     = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   obj_valid_i,
  output logic                   obj_ready_o,
  input  ssop_pkg::obj_t         obj_i,
  input  logic [5:0][63:0]       cols_i,
  input  logic [10:0]            cursor_x_i,
  input  logic [9:0]             cursor_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [15:0]            picked_id_o,
  output logic                   selected_o,
  output logic signed [31:0]     screen_x_o,
  output logic signed [31:0]     screen_y_o,
  output logic                   degenerate_o
);
  import ssop_pkg::*;

  localparam logic signed [63:0] SMax = 64'sd2147483647;
  localparam logic signed [63:0] SMin = -64'sd2147483648;
  localparam logic [63:0] QLimit = 64'd1 << (32 - FracBits);

  back_state_e state_q, state_d;

  obj_t obj_q;
  // pt: 0 = centre, 1 = offset point. row: 0..2 products; comp: 0..2 clip x/y/w.
  logic        pt_q, pt_d;
  logic [1:0]  comp_q, comp_d;
  logic [1:0]  row_q, row_d;
  logic        axis_q, axis_d;      // 0 = screen x, 1 = screen y
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] clip_q [2][3];
  logic signed [31:0] scr_q [2][2];
  logic signed [63:0] num_q;
  logic signed [63:0] den_q;
  logic        neg_q;
  logic        hit_seen_q, hit_seen_d;
  logic        sel_q, degen_q;
  logic [63:0] dsq_q;
  logic [64:0] dist_q [2];
  logic        dstep_q, dstep_d;   // which distance, which axis term
  logic        dax_q, dax_d;

  logic        prod_en, clip_en, num_en, scr_en, dsq_en, dist_en, out_en, load;
  logic        div_start, div_busy;
  logic [63:0] div_num, div_den, div_quo, div_rem;

  // Product operand selection: one 32x33 multiply, its product registered in StMul.
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic [63:0]        reg_sel;
  logic signed [63:0] mul_p;

  always_comb begin
    unique case (row_q)
      2'd0:    mul_a = pt_q ? ($signed({obj_q.world_x[31], obj_q.world_x})
                        + $signed({2'b00, obj_q.scale_x[30:1]}))
                      : $signed({obj_q.world_x[31], obj_q.world_x});
      2'd1:    mul_a = $signed({obj_q.world_y[31], obj_q.world_y});
      default: mul_a = $signed({obj_q.world_z[31], obj_q.world_z});
    endcase
    reg_sel = cols_i[{comp_q, row_q[1]}];
    mul_b = row_q[0] ? $signed(reg_sel[63:32]) : $signed(reg_sel[31:0]);
    mul_p = 64'(mul_a * mul_b);
  end

  // Floor shift of a product and saturation of the clip sum. The clip sum is
  // taken in the cycle that adds the last product.
  logic signed [63:0] prod_sh, clip_sum;
  logic signed [31:0] row3, clip_sat;
  always_comb begin
    prod_sh = prod_q >>> FracBits;
    row3 = $signed(cols_i[{comp_q, 1'b1}][63:32]);
    clip_sum = acc_q + prod_sh + 64'(row3);
    if (clip_sum > SMax) clip_sat = 32'sh7fffffff;
    else if (clip_sum < SMin) clip_sat = 32'sh80000000;
    else clip_sat = clip_sum[31:0];
  end

  // Screen numerator and denominator for the current point and axis.
  logic signed [31:0] cw, cc;
  logic signed [33:0] nbase;
  logic signed [63:0] nfull, dfull;
  always_comb begin
    cw = clip_q[pt_q][2];
    cc = axis_q ? clip_q[pt_q][1] : clip_q[pt_q][0];
    nbase = axis_q ? (34'(cw) - 34'(cc)) : (34'(cc) + 34'(cw));
    nfull = 64'(nbase * $signed({1'b0, axis_q ? 14'(ScreenHeight) : 14'(ScreenWidth)}));
    dfull = 64'(cw) <<< 1;
  end

  // Magnitude rebuild after division.
  logic [63:0] mag;
  logic signed [63:0] sres;
  logic signed [31:0] sres_sat;
  always_comb begin
    if (div_quo > QLimit) mag = 64'd1 << 32;
    else mag = (div_quo << FracBits) + (div_rem << FracBits);
    sres = neg_q ? -$signed(mag) : $signed(mag);
    if (sres > SMax) sres_sat = 32'sh7fffffff;
    else if (sres < SMin) sres_sat = 32'sh80000000;
    else sres_sat = sres[31:0];
  end

  // The fractional part needs a second division of (r << F) by d, run
  // unless the integer quotient exceeds QLimit: stage flag in frac_q.
  logic frac_q, frac_d;
  logic [63:0] q_int_q;

  // Distance terms.
  logic signed [31:0] mx, my, da, db;
  logic signed [32:0] dd;
  logic [32:0] dabs;
  always_comb begin
    mx = (64'(cursor_x_i) << FracBits) > 64'(SMax) ? 32'sh7fffffff
         : 32'(64'(cursor_x_i) << FracBits);
    my = (64'(cursor_y_i) << FracBits) > 64'(SMax) ? 32'sh7fffffff
         : 32'(64'(cursor_y_i) << FracBits);
    da = dax_q ? scr_q[0][1] : scr_q[0][0];
    db = dstep_q ? (dax_q ? my : mx) : (dax_q ? scr_q[1][1] : scr_q[1][0]);
    dd = 33'(da) - 33'(db);
    dabs = dd[32] ? 33'(-dd) : dd;
  end

  assign obj_ready_o  = (state_q == StIdle);
  assign out_valid_o  = (state_q == StOut);
  assign picked_id_o  = obj_q.object_id;
  assign selected_o   = sel_q;
  assign screen_x_o   = scr_q[0][0];
  assign screen_y_o   = scr_q[0][1];
  assign degenerate_o = degen_q;

  logic hit;
  assign hit = dist_q[0] > dist_q[1];

  function automatic logic degen_w();
    return (clip_q[0][2] == 32'sd0) || (clip_q[1][2] == 32'sd0);
  endfunction

  function automatic logic signed [31:0] sat_mag(logic [63:0] qi, logic [63:0] qf,
                                                 logic ng);
    logic [63:0] m;
    logic signed [63:0] s;
    m = (qi << FracBits) + qf;
    s = ng ? -$signed(m) : $signed(m);
    if (s > SMax) return 32'sh7fffffff;
    if (s < SMin) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_comb begin
    state_d = state_q;
    pt_d = pt_q; comp_d = comp_q; row_d = row_q; axis_d = axis_q;
    acc_d = acc_q; frac_d = frac_q;
    hit_seen_d = hit_seen_q;
    dstep_d = dstep_q; dax_d = dax_q;
    load = 1'b0; prod_en = 1'b0; clip_en = 1'b0; num_en = 1'b0;
    scr_en = 1'b0; dsq_en = 1'b0; dist_en = 1'b0; out_en = 1'b0;
    div_start = 1'b0;
    div_num = '0; div_den = '0;
    unique case (state_q)
      StIdle: begin
        if (obj_valid_i) begin
          load = 1'b1;
          pt_d = 1'b0; comp_d = 2'd0; row_d = 2'd0; acc_d = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        prod_en = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        acc_d = acc_q + prod_sh;
        if (row_q == 2'd2) begin
          clip_en = 1'b1;
          row_d = 2'd0;
          acc_d = '0;
          if (comp_q == 2'd2) begin
            comp_d = 2'd0;
            if (pt_q) begin
              pt_d = 1'b0; axis_d = 1'b0;
              state_d = StScreenNum;
            end else begin
              pt_d = 1'b1;
              state_d = StMul;
            end
          end else begin
            comp_d = comp_q + 2'd1;
            state_d = StMul;
          end
        end else begin
          row_d = row_q + 2'd1;
          state_d = StMul;
        end
      end
      StScreenNum: begin
        if (cw == 32'sd0) begin
          scr_en = 1'b1;
          if (axis_q) begin
            axis_d = 1'b0;
            if (pt_q) state_d = StDecide;
            else begin
              pt_d = 1'b1;
              state_d = (clip_q[1][2] == 32'sd0 || clip_q[0][2] == 32'sd0) ? StDecide
                        : StScreenNum;
            end
          end else axis_d = 1'b1;
        end else begin
          num_en = 1'b1;
          frac_d = 1'b0;
          state_d = StDivStart;
        end
      end
      StDivStart: begin
        div_start = 1'b1;
        div_num = frac_q ? (div_rem << FracBits) : (num_q[63] ? 64'(-num_q) : num_q);
        div_den = den_q[63] ? 64'(-den_q) : den_q;
        state_d = StDivRun;
      end
      StDivRun: begin
        if (!div_busy) state_d = StDivDone;
      end
      StDivDone: begin
        if (!frac_q && div_quo <= QLimit) begin
          frac_d = 1'b1;
          state_d = StDivStart;
        end else begin
          scr_en = 1'b1;
          if (axis_q) begin
            axis_d = 1'b0;
            if (pt_q || clip_q[1][2] == 32'sd0) begin
              dstep_d = 1'b0; dax_d = 1'b0;
              state_d = (pt_q) ? StDist : StDecide;
            end else begin
              pt_d = 1'b1;
              state_d = StScreenNum;
            end
          end else begin
            axis_d = 1'b1;
            state_d = StScreenNum;
          end
        end
      end
      StDist: begin
        dsq_en = 1'b1;
        state_d = StDistAdd;
      end
      StDistAdd: begin
        dist_en = 1'b1;
        if (dax_q) begin
          dax_d = 1'b0;
          if (dstep_q) state_d = StDecide;
          else begin
            dstep_d = 1'b1;
            state_d = StDist;
          end
        end else begin
          dax_d = 1'b1;
          state_d = StDist;
        end
      end
      StDecide: begin
        out_en = 1'b1;
        if (obj_q.layer_first) hit_seen_d = 1'b0;
        if (!degen_w() && hit && !(hit_seen_q && !obj_q.layer_first)) hit_seen_d = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  ssop_div #(.Width(64)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      hit_seen_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hit_seen_q <= hit_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d; comp_q <= comp_d; row_q <= row_d; axis_q <= axis_d;
    acc_q <= acc_d; frac_q <= frac_d; dstep_q <= dstep_d; dax_q <= dax_d;
    if (load) begin
      obj_q <= obj_i;
      scr_q[0][0] <= '0;
      scr_q[0][1] <= '0;
      dist_q[0] <= '0;
      dist_q[1] <= '0;
    end
    if (prod_en) prod_q <= mul_p;
    if (clip_en) clip_q[pt_q][comp_q] <= clip_sat;
    if (num_en) begin
      num_q <= nfull;
      den_q <= dfull;
      neg_q <= nfull[63] ^ dfull[63];
    end
    if (state_q == StDivDone && !frac_q) q_int_q <= div_quo;
    if (scr_en) begin
      if (cw == 32'sd0) scr_q[pt_q][axis_q] <= '0;
      else if (frac_q) begin
        scr_q[pt_q][axis_q] <= sat_mag(q_int_q, div_quo, neg_q);
      end else scr_q[pt_q][axis_q] <= sres_sat;
    end
    if (dsq_en) dsq_q <= 64'(dabs * dabs);
    if (dist_en) dist_q[dstep_q] <= dist_q[dstep_q] + 65'(dsq_q);
    if (out_en) begin
      degen_q <= degen_w();
      sel_q   <= !degen_w() && hit && (obj_q.layer_first || !hit_seen_q);
    end
  end

endmodule

[sv/ssop_checker.sv]
module ssop_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic        selected_o,
  input logic        degenerate_o,
  input logic [15:0] picked_id_o
);
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(picked_id_o))
    else $error("result dropped while stalled");
  a_sel_nondegen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(selected_o && degenerate_o))
    else $error("degenerate object selected");
  a_one_cycle_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i |=> !res_valid_o)
    else $error("result repeated");
endmodule

bind screen_space_object_pick_core ssop_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .res_valid_o(res_valid_o),
  .res_ready_i(res_ready_i), .selected_o(selected_o),
  .degenerate_o(degenerate_o), .picked_id_o(picked_id_o)
);
